// File: hdl/cosine_dome_height_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cosine dome height unit
// Concurrent checks are clocked on clk_i and masked while rst_ni is low.
// They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COSINE_DOME_HEIGHT_UNIT_ASSERT_SVH
`define COSINE_DOME_HEIGHT_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check cons in the same cycle as ante
`define CDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante
`define CDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CDH_ASSERT_NOW(lbl, ante, cons, msg)
`define CDH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/cdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine dome height package
// Widths, pipeline layout, register indexes and the cosine series
// coefficients shared by the dome height unit and its channels.
// ----------------------------------------------------------------------------
package cdh_pkg;

  // Coordinate and size width (Q8.8; the fixed-point scale cancels in t)
  localparam int unsigned COORD_BITS = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [COORD_BITS-1:0] SIZE_X_RST = 16'd512;
  localparam logic [COORD_BITS-1:0] SIZE_Y_RST = 16'd512;
  localparam logic [COORD_BITS-1:0] SIZE_Z_RST = 16'd256;

  // Normalized distance t has T_FRAC fraction bits; dividend is 2|v| << T_FRAC
  localparam int unsigned T_FRAC         = 16;
  localparam int unsigned DIV_SHIFT      = T_FRAC + 1;
  localparam int unsigned DIV_W_RAW      = COORD_BITS + DIV_SHIFT;
  localparam int unsigned BITS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES     = (DIV_W_RAW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int unsigned DIV_W          = DIV_STAGES * BITS_PER_STAGE;

  // Phase constants (T_FRAC+1 bits hold t mod 2)
  localparam logic [T_FRAC:0] PH_ONE  = {1'b1, {T_FRAC{1'b0}}};
  localparam logic [T_FRAC:0] PH_HALF = {2'b01, {(T_FRAC-1){1'b0}}};

  // Folded phase s <= 1/2, and s^2 with 30 fraction bits
  localparam int unsigned S_W  = T_FRAC;
  localparam int unsigned S2_W = 2 * S_W - 2;

  // Horner evaluation of the cosine series in Q30
  localparam int unsigned Q30      = 30;
  localparam int unsigned R_W      = 33;
  localparam int unsigned HORNER_N = 6;
  localparam logic [R_W-1:0] HORNER_SEED = 33'd2071865;
  localparam logic [R_W-1:0] HORNER_SUB [HORNER_N] = '{
    33'd27709939,
    33'd252684340,
    33'd1433727481,
    33'd4358008962,
    33'd5298703516,
    33'd1073741824
  };
  localparam logic [R_W-1:0] ONE_Q30 = 33'd1073741824;

  // Scaling by size_z/2 with round half up
  localparam int unsigned M_W    = COORD_BITS + 1;
  localparam int unsigned ZP_W   = COORD_BITS + R_W + 1;
  localparam logic [ZP_W-1:0] ROUND_HALF = ZP_W'(ONE_Q30);
  localparam logic [M_W-1:0] NEG_LIMIT = {1'b0, 1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [M_W-1:0] POS_LIMIT = {2'b00, {(COORD_BITS-1){1'b1}}};

  // Pipeline layout: magnitude, divider, fold, square, Horner, scale, saturate
  localparam int unsigned ST_MAG   = 0;
  localparam int unsigned ST_FOLD  = DIV_STAGES + 1;
  localparam int unsigned ST_SQ    = DIV_STAGES + 2;
  localparam int unsigned ST_H0    = DIV_STAGES + 3;
  localparam int unsigned ST_M     = ST_H0 + HORNER_N;
  localparam int unsigned ST_OUT   = ST_M + 1;
  localparam int unsigned N_STAGES = ST_OUT + 1;

endpackage

// File: hdl/cdh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying one vertex (x, y) per word.
// ----------------------------------------------------------------------------
interface cdh_in_if;
  import cdh_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;

  modport source (output valid, output vert_x, output vert_y, input ready);
  modport sink   (input valid, input vert_x, input vert_y, output ready);
endinterface

// File: hdl/cdh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height output channel
// Valid/ready channel carrying one vertex height per word.
// ----------------------------------------------------------------------------
interface cdh_out_if;
  import cdh_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_z;

  modport source (output valid, output vert_z, input ready);
  modport sink   (input valid, input vert_z, output ready);
endinterface

// File: hdl/cdh_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined radial divider
// Computes (mag << DIV_SHIFT) / den by restoring division, BITS_PER_STAGE
// quotient bits per register stage. All stages advance together on en_i.
// ----------------------------------------------------------------------------
module cdh_div_pipe (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [cdh_pkg::COORD_BITS-1:0] mag_i,
  input  logic [cdh_pkg::COORD_BITS-1:0] den_i,
  output logic [cdh_pkg::DIV_W-1:0]      quo_o
);
  import cdh_pkg::*;

  logic [COORD_BITS-1:0] rem_q [DIV_STAGES];
  logic [DIV_W-1:0]      quo_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [COORD_BITS-1:0] rem_in;
    logic [DIV_W-1:0]      quo_in;
    logic [COORD_BITS-1:0] rem_d;
    logic [DIV_W-1:0]      quo_d;
    logic [COORD_BITS:0]   part;

    // Seed the first stage with the shifted dividend
    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = DIV_W'({mag_i, {DIV_SHIFT{1'b0}}});
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // Shift in BITS_PER_STAGE dividend bits one at a time, subtracting when the partial remainder allows
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      part  = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        part  = {rem_d, quo_d[DIV_W-1]};
        quo_d = {quo_d[DIV_W-2:0], 1'b0};
        if (part >= {1'b0, den_i}) begin
          part     = part - {1'b0, den_i};
          quo_d[0] = 1'b1;
        end
        rem_d = part[COORD_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        quo_q[g] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// File: hdl/cosine_dome_height_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine dome height unit
// Returns size_z/2 * cos(pi*t) for each vertex, t = max(2|x|/size_x,
// 2|y|/size_y), in saturated signed Q8.8.
// ----------------------------------------------------------------------------
// The unit takes one vertex per clock while the output is not stalled and
// returns the heights in order. The two radial dividers resolve three
// quotient bits per stage over 33 bits; the cosine series then takes one
// multiplier stage per Horner term. A word is accepted while a
// finished height waits at the output: a one-word skid register holds it, and
// after a stall ends the input is not ready for one cycle while that register
// drains. A zero size_x or size_y is treated as one. Write size_x, size_y
// and size_z only while no vertex is in flight.
// ----------------------------------------------------------------------------
`include "cosine_dome_height_unit_assert.svh"

module cosine_dome_height_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cdh_pkg::COORD_BITS-1:0] cfg_wdata_i,
  cdh_in_if.sink                         vin_i,
  cdh_out_if.source                      vout_o
);
  import cdh_pkg::*;

  // Configuration registers
  logic [COORD_BITS-1:0] size_x_q, size_y_q, size_z_q;

  // Flow control
  logic                  en;
  logic                  accept;
  logic [N_STAGES-1:0]   vld_q;
  logic                  skid_v_q, skid_v_d;
  logic [COORD_BITS-1:0] skid_x_q, skid_y_q;
  logic                  src_v;
  logic [COORD_BITS-1:0] src_x, src_y;

  // Datapath
  logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
  logic [COORD_BITS-1:0] den_x, den_y;
  logic [DIV_W-1:0]      quo_x, quo_y;
  logic [DIV_W-1:0]      t_max;
  logic [T_FRAC:0]       ph, ph_fold;
  logic [S_W-1:0]        s_d, s_q;
  logic                  fneg_d, fneg_q;
  logic [2*S_W-1:0]      sq;
  logic [S2_W-1:0]       s2_q [HORNER_N];
  logic                  neg_q [HORNER_N+1];
  logic [R_W-1:0]        r_q [HORNER_N];
  logic [ZP_W-1:0]       zprod;
  logic [M_W-1:0]        m_q;
  logic                  m_neg_q;
  logic [M_W-1:0]        m_sat;
  logic [COORD_BITS-1:0] vert_z_d, vert_z_q;

  // Write configuration; ignore indexes past the last register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_X_RST;
      size_y_q <= SIZE_Y_RST;
      size_z_q <= SIZE_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_wdata_i;
        REG_SIZE_Y: size_y_q <= cfg_wdata_i;
        REG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output word is held
  assign en     = !vld_q[N_STAGES-1] || vout_o.ready;
  assign accept = vin_i.valid && !skid_v_q;
  assign vin_i.ready = !skid_v_q;

  // Park an accepted word in the skid register while stalled
  always_comb begin
    skid_v_d = skid_v_q;
    if (en) begin
      skid_v_d = 1'b0;
    end else if (accept) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && accept) begin
      skid_x_q <= vin_i.vert_x;
      skid_y_q <= vin_i.vert_y;
    end
  end

  // Feed the pipeline from the skid register first
  assign src_v = skid_v_q || accept;
  assign src_x = skid_v_q ? skid_x_q : vin_i.vert_x;
  assign src_y = skid_v_q ? skid_y_q : vin_i.vert_y;

  // Shift valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGES-2:0], src_v};
    end
  end

  // Stage: absolute values of the coordinates
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_x_q <= src_x[COORD_BITS-1] ? COORD_BITS'(-src_x) : src_x;
      mag_y_q <= src_y[COORD_BITS-1] ? COORD_BITS'(-src_y) : src_y;
    end
  end

  // Stages: radial ratios 2|v|/size, zero size taken as one
  assign den_x = (size_x_q == '0) ? COORD_BITS'(1) : size_x_q;
  assign den_y = (size_y_q == '0) ? COORD_BITS'(1) : size_y_q;

  cdh_div_pipe u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_x_q),
    .den_i (den_x),
    .quo_o (quo_x)
  );

  cdh_div_pipe u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_y_q),
    .den_i (den_y),
    .quo_o (quo_y)
  );

  // Stage: take the larger ratio, reduce mod 2 and fold into [0, 1/2]
  always_comb begin
    t_max   = (quo_x > quo_y) ? quo_x : quo_y;
    ph      = t_max[T_FRAC:0];
    ph_fold = (ph > PH_ONE) ? (T_FRAC+1)'(-ph) : ph;
    if (ph_fold > PH_HALF) begin
      s_d    = S_W'(PH_ONE - ph_fold);
      fneg_d = 1'b1;
    end else begin
      s_d    = S_W'(ph_fold);
      fneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q    <= s_d;
      fneg_q <= fneg_d;
    end
  end

  // Stage: s^2 in Q30
  assign sq = s_q * s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q[0]  <= sq[2 +: S2_W];
      neg_q[0] <= fneg_q;
    end
  end

  // Stages: one Horner term each, truncate the product and clamp at zero
  for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
    logic [R_W-1:0]      r_in;
    logic [R_W+S2_W-1:0] prod;
    logic [R_W-1:0]      prod_sh;
    logic [R_W-1:0]      r_d;

    if (j == 0) begin : g_seed
      assign r_in = HORNER_SEED;
    end else begin : g_chain
      assign r_in = r_q[j-1];
    end

    assign prod    = r_in * s2_q[j];
    assign prod_sh = prod[Q30 +: R_W];
    assign r_d     = (prod_sh > HORNER_SUB[j]) ? '0 : HORNER_SUB[j] - prod_sh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[j]     <= r_d;
        neg_q[j+1] <= neg_q[j];
      end
    end

    if (j < HORNER_N - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en) begin
          s2_q[j+1] <= s2_q[j];
        end
      end
    end
  end

  // Stage: scale by size_z/2, round half up
  assign zprod = ZP_W'(size_z_q) * ZP_W'(r_q[HORNER_N-1]) + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q     <= zprod[Q30+1 +: M_W];
      m_neg_q <= neg_q[HORNER_N];
    end
  end

  // Stage: saturate and apply the sign
  always_comb begin
    if (m_neg_q) begin
      m_sat    = (m_q > NEG_LIMIT) ? NEG_LIMIT : m_q;
      vert_z_d = COORD_BITS'(-m_sat);
    end else begin
      m_sat    = (m_q > POS_LIMIT) ? POS_LIMIT : m_q;
      vert_z_d = m_sat[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vert_z_q <= vert_z_d;
    end
  end

  assign vout_o.valid  = vld_q[ST_OUT];
  assign vout_o.vert_z = vert_z_q;

  // Checks
  `CDH_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_q), "pipeline advanced while stalled")
  `CDH_ASSERT_NOW(a_skid_fill, $rose(skid_v_q), $past(!en), "skid filled without a stall")
  `CDH_ASSERT_NOW(a_cos_bound, vld_q[ST_M-1], r_q[HORNER_N-1] <= ONE_Q30, "cosine above one")
  `CDH_ASSERT_NOW(a_mag_bound, vld_q[ST_M], m_q <= NEG_LIMIT, "scaled height out of range")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine dome height unit testbench
// Streams vertices through the unit under random source gaps and sink
// stalls, predicts each height with a bit-exact fixed-point dome model and
// compares every returned word in order. Runs directed corner vertices first,
// then random vertices over several size settings, zero and full-scale among
// them.
// ----------------------------------------------------------------------------
module tb;
  import cdh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 125;

  // Cosine series terms pi^(2k)/(2k)! in Q30, highest order first, then one
  localparam logic [63:0] COS_SEED = 64'd2071865;
  localparam logic [63:0] COS_TERM [6] = '{
    64'd27709939,
    64'd252684340,
    64'd1433727481,
    64'd4358008962,
    64'd5298703516,
    64'd1073741824
  };
  localparam logic [63:0] HALF_Q31 = 64'd1073741824;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } height_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [COORD_BITS-1:0] cfg_wdata_i = '0;

  cdh_in_if  vin ();
  cdh_out_if vout ();

  cosine_dome_height_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vin_i       (vin),
    .vout_o      (vout)
  );

  // Shadow copy of the size registers
  logic [COORD_BITS-1:0] cur_size_x = SIZE_X_RST;
  logic [COORD_BITS-1:0] cur_size_y = SIZE_Y_RST;
  logic [COORD_BITS-1:0] cur_size_z = SIZE_Z_RST;

  vertex_t     pending_verts [$];
  height_rec_t heights_due [$];
  int          words_queued  = 0;
  int          words_checked = 0;
  int          fail_count    = 0;
  int          idle_cycles   = 0;
  int          drv_gap;
  int          mon_stall;
  logic        drv_quiet;
  logic        mon_quiet;

  always #5 clk_i = ~clk_i;

  // Height of one vertex on the dome for the current sizes
  function automatic logic signed [COORD_BITS-1:0] dome_height(
    input logic signed [COORD_BITS-1:0] vx,
    input logic signed [COORD_BITS-1:0] vy
  );
    logic [63:0] ux, uy, ax, ay, dx, dy, tx, ty, t, p, s, s2, r, prod, m;
    logic        neg;
    ux = {48'd0, vx};
    uy = {48'd0, vy};
    ax = vx[COORD_BITS-1] ? (64'd65536 - ux) : ux;
    ay = vy[COORD_BITS-1] ? (64'd65536 - uy) : uy;
    dx = (cur_size_x == '0) ? 64'd1 : {48'd0, cur_size_x};
    dy = (cur_size_y == '0) ? 64'd1 : {48'd0, cur_size_y};
    tx = (ax << 17) / dx;
    ty = (ay << 17) / dy;
    t  = (tx > ty) ? tx : ty;
    // Fold the phase into [0, 1/2] and remember the sign of the cosine
    p  = t & 64'h1FFFF;
    if (p > 64'd65536) p = 64'd131072 - p;
    neg = 1'b0;
    if (p > 64'd32768) begin
      s   = 64'd65536 - p;
      neg = 1'b1;
    end else begin
      s = p;
    end
    s2 = (s * s) >> 2;
    // Horner series, each step truncated and clamped at zero
    r = COS_SEED;
    for (int k = 0; k < 6; k++) begin
      prod = (r * s2) >> 30;
      r    = (prod > COS_TERM[k]) ? 64'd0 : COS_TERM[k] - prod;
    end
    m = ({48'd0, cur_size_z} * r + HALF_Q31) >> 31;
    if (neg) begin
      if (m > 64'd32768) m = 64'd32768;
      return COORD_BITS'(64'd0 - m);
    end
    if (m > 64'd32767) m = 64'd32767;
    return COORD_BITS'(m);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Drive vertex words from the pending queue, predict at acceptance
  always @(posedge clk_i or negedge rst_ni) begin : vertex_driver
    vertex_t nxt;
    if (!rst_ni) begin
      vin.valid  <= 1'b0;
      vin.vert_x <= '0;
      vin.vert_y <= '0;
      drv_gap    <= 0;
      drv_quiet  <= 1'b0;
    end else begin
      if (vin.valid && vin.ready)
        heights_due.push_back('{x: vin.vert_x, y: vin.vert_y,
                                z: dome_height(vin.vert_x, vin.vert_y)});
      if (!vin.valid || vin.ready) begin
        if (drv_gap > 0) begin
          vin.valid <= 1'b0;
          drv_gap   <= drv_gap - 1;
        end else if (pending_verts.size() != 0) begin
          nxt = pending_verts.pop_front();
          vin.valid  <= 1'b1;
          vin.vert_x <= nxt.x;
          vin.vert_y <= nxt.y;
          drv_gap    <= drv_quiet ? 0 : $urandom_range(0, 10);
          if ($urandom_range(0, 31) == 0) drv_quiet <= !drv_quiet;
        end else begin
          vin.valid <= 1'b0;
        end
      end
    end
  end

  // Check height words against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : height_monitor
    int          stall;
    height_rec_t due;
    if (!rst_ni) begin
      vout.ready <= 1'b0;
      mon_stall  <= 0;
      mon_quiet  <= 1'b0;
    end else begin
      if (vout.valid && vout.ready) begin
        if (heights_due.size() == 0) begin
          report_mismatch($sformatf("unexpected height word %0d", vout.vert_z));
        end else begin
          due = heights_due.pop_front();
          words_checked++;
          if (vout.vert_z !== due.z)
            report_mismatch($sformatf("vertex (%0d,%0d): vert_z %0d, expected %0d",
                                      due.x, due.y, vout.vert_z, due.z));
        end
        stall = mon_quiet ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 31) == 0) mon_quiet <= !mon_quiet;
        mon_stall  <= stall;
        vout.ready <= (stall == 0);
      end else if (mon_stall > 0) begin
        mon_stall  <= mon_stall - 1;
        vout.ready <= (mon_stall == 1);
      end else begin
        vout.ready <= 1'b1;
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL cosine_dome_height_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_vertex(input int x, input int y);
    pending_verts.push_back('{x: COORD_BITS'(x), y: COORD_BITS'(y)});
    words_queued++;
  endtask

  // Hold until every queued vertex has come back as a height
  task automatic wait_drained();
    while (words_checked != words_queued) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIZE_X: cur_size_x = val;
      REG_SIZE_Y: cur_size_y = val;
      REG_SIZE_Z: cur_size_z = val;
      default: ;
    endcase
  endtask

  // Coordinate scaled to the rectangle so t mostly spans 0 to 2.5
  function automatic int scaled_coord(input logic [COORD_BITS-1:0] size);
    int lim;
    int v;
    lim = int'(size) + int'(size) / 4 + 1;
    if (lim > 32768) lim = 32768;
    v = $urandom_range(0, lim);
    if ($urandom_range(0, 1)) v = -v;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task automatic queue_random(input int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 15)
        queue_vertex($urandom_range(0, 65535), $urandom_range(0, 65535));
      else if (kind < 23)
        queue_vertex(0, scaled_coord(cur_size_y));
      else if (kind < 30)
        queue_vertex(scaled_coord(cur_size_x), 0);
      else
        queue_vertex(scaled_coord(cur_size_x), scaled_coord(cur_size_y));
    end
  endtask

  // Reconfigure while idle, then stream vertices with a full drain midway
  task automatic run_phase(input logic [COORD_BITS-1:0] sx,
                           input logic [COORD_BITS-1:0] sy,
                           input logic [COORD_BITS-1:0] sz,
                           input int n);
    wait_drained();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_UNUSED, COORD_BITS'($urandom_range(0, 65535)));
    queue_random(n / 2);
    wait_drained();
    queue_random(n - n / 2);
  endtask

  initial begin
    logic [COORD_BITS-1:0] sx, sy, sz;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed vertices at reset sizes: centre, edges, half points, corners
    queue_vertex(0, 0);
    queue_vertex(256, 0);
    queue_vertex(0, 256);
    queue_vertex(128, 0);
    queue_vertex(0, -128);
    queue_vertex(127, 0);
    queue_vertex(129, 0);
    queue_vertex(-256, -256);
    queue_vertex(384, 0);
    queue_vertex(512, 0);
    queue_vertex(100, 200);
    queue_vertex(200, -100);
    queue_vertex(-1, 1);
    queue_vertex(-1, 0);
    queue_vertex(255, 0);
    queue_vertex(257, 0);
    queue_vertex(32767, 32767);
    queue_vertex(-32768, -32768);
    queue_vertex(32767, -32768);
    queue_vertex(-32768, 0);
    queue_vertex(0, 32767);
    queue_random(PHASE_ITEMS);

    // Unit sizes and full height: the centre saturates positive
    wait_drained();
    write_reg(REG_SIZE_X, 16'd1);
    write_reg(REG_SIZE_Y, 16'd1);
    write_reg(REG_SIZE_Z, 16'hFFFF);
    queue_vertex(0, 0);
    queue_vertex(1, 0);
    queue_vertex(0, -1);
    queue_random(PHASE_ITEMS);

    run_phase(16'hFFFF, 16'hFFFF, 16'd0, PHASE_ITEMS);
    run_phase(16'd0, 16'd0, 16'hFFFF, PHASE_ITEMS);
    run_phase(16'hFFFF, 16'd1, 16'd32768, PHASE_ITEMS);
    repeat (3) begin
      sx = COORD_BITS'($urandom_range(0, 1) ? $urandom_range(1, 65535)
                                            : $urandom_range(1, 1024));
      sy = COORD_BITS'($urandom_range(0, 1) ? $urandom_range(1, 65535)
                                            : $urandom_range(1, 1024));
      sz = COORD_BITS'($urandom_range(0, 65535));
      run_phase(sx, sy, sz, PHASE_ITEMS);
    end

    wait_drained();
    repeat (N_STAGES + 16) @(posedge clk_i);
    if (heights_due.size() != 0)
      report_mismatch($sformatf("%0d heights never arrived", heights_due.size()));
    if (fail_count == 0) begin
      $display("PASS cosine_dome_height_unit");
    end else begin
      $display("FAIL cosine_dome_height_unit");
    end
    $finish;
  end

endmodule
